### src/text_row_limited_integer_sum_assert.svh
// ----------------------------------------------------------------------------
// text_row_limited_integer_sum_assert.svh
// assertion macros shared by the integer sum block
// ----------------------------------------------------------------------------
`ifndef TEXT_ROW_LIMITED_INTEGER_SUM_ASSERT_SVH
`define TEXT_ROW_LIMITED_INTEGER_SUM_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define TRLIS_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("trlis: same-cycle check failed");

// antecedent implies consequent in the following cycle
`define TRLIS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("trlis: next-cycle check failed");

`endif

### src/trlis_pkg.sv
// ----------------------------------------------------------------------------
// trlis_pkg
// types and constants for the text row limited integer sum block
// ----------------------------------------------------------------------------
package trlis_pkg;

  // ascii codes the parser reacts to
  localparam logic [7:0] CHAR_MINUS   = 8'h2D;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_NINE    = 8'h39;

  // result kinds
  localparam logic KIND_WARN = 1'b0;
  localparam logic KIND_SUM  = 1'b1;

  // register map, word index taken from paddr[2]
  localparam logic REG_PER_ROW_LIMIT = 1'b0;

  localparam logic [15:0] LIMIT_RESET = 16'hFFFF;
  localparam logic [15:0] ROW_COUNT_MAX = 16'hFFFF;

  // one queued record: a warning, a sum, or both (warning first)
  typedef struct packed {
    logic        has_warn;
    logic [31:0] warn_value;
    logic [31:0] warn_row;
    logic        has_sum;
    logic [31:0] total;
  } rec_t;

  // queue status towards the top level
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

### src/trlis_front.sv
// ----------------------------------------------------------------------------
// trlis_front
// byte parser: tracks numbers, row limit, line number and running sum
// ----------------------------------------------------------------------------
module trlis_front (
  input  logic                clk,
  input  logic                rst,
  input  logic [15:0]         per_row_limit,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          text_byte,
  input  logic                is_end,
  input  logic                q_full,
  output logic                push,
  output trlis_pkg::rec_t     push_rec
);

  logic        in_number;
  logic        is_negative;
  logic        saw_digit;
  logic [31:0] magnitude;
  logic        skip_current;
  logic [15:0] row_count;
  logic        row_skip;
  logic [31:0] line_number;
  logic [31:0] running_sum;

  logic        in_number_next;
  logic        is_negative_next;
  logic        saw_digit_next;
  logic [31:0] magnitude_next;
  logic        skip_current_next;
  logic [15:0] row_count_next;
  logic        row_skip_next;
  logic [31:0] line_number_next;
  logic [31:0] running_sum_next;

  logic        accept;
  logic        is_digit;
  logic [3:0]  digit;
  logic        close_en;
  logic        counted;
  logic [31:0] value;
  logic        close_warn;
  logic        close_add;
  logic [31:0] sum_after;
  logic [15:0] row_inc;
  logic [15:0] row_after;
  logic        skip_after;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // byte classification
  assign is_digit = (text_byte >= trlis_pkg::CHAR_ZERO) && (text_byte <= trlis_pkg::CHAR_NINE);
  assign digit    = 4'(text_byte - trlis_pkg::CHAR_ZERO);

  // closing the pending number
  assign close_en   = in_number && (is_end || !is_digit);
  assign counted    = close_en && saw_digit;
  assign value      = is_negative ? (32'd0 - magnitude) : magnitude;
  assign close_warn = counted && !skip_current && value[31];
  assign close_add  = counted && !skip_current && !value[31];
  assign sum_after  = running_sum + (close_add ? value : 32'd0);
  assign row_inc    = (row_count < trlis_pkg::ROW_COUNT_MAX) ? row_count + 16'd1 : row_count;
  assign row_after  = counted ? row_inc : row_count;
  assign skip_after = row_skip || (counted && (row_inc >= per_row_limit));

  // next state
  always_comb begin
    in_number_next    = in_number;
    is_negative_next  = is_negative;
    saw_digit_next    = saw_digit;
    magnitude_next    = magnitude;
    skip_current_next = skip_current;
    row_count_next    = row_count;
    row_skip_next     = row_skip;
    line_number_next  = line_number;
    running_sum_next  = running_sum;
    if (is_end) begin
      in_number_next    = 1'b0;
      is_negative_next  = 1'b0;
      saw_digit_next    = 1'b0;
      magnitude_next    = 32'd0;
      skip_current_next = 1'b0;
      row_count_next    = 16'd0;
      row_skip_next     = 1'b0;
      line_number_next  = 32'd1;
      running_sum_next  = 32'd0;
    end else if (in_number && is_digit) begin
      saw_digit_next = 1'b1;
      magnitude_next = (magnitude << 3) + (magnitude << 1) + 32'(digit);
    end else begin
      in_number_next   = 1'b0;
      row_count_next   = row_after;
      row_skip_next    = skip_after;
      running_sum_next = sum_after;
      if (is_digit || (text_byte == trlis_pkg::CHAR_MINUS)) begin
        in_number_next    = 1'b1;
        is_negative_next  = !is_digit;
        saw_digit_next    = is_digit;
        magnitude_next    = is_digit ? 32'(digit) : 32'd0;
        skip_current_next = skip_after;
      end
      if (text_byte == trlis_pkg::CHAR_NEWLINE) begin
        line_number_next = line_number + 32'd1;
        row_count_next   = 16'd0;
        row_skip_next    = 1'b0;
      end
    end
  end

  // record towards the queue
  assign push                = accept && (close_warn || is_end);
  assign push_rec.has_warn   = close_warn;
  assign push_rec.warn_value = value;
  assign push_rec.warn_row   = line_number;
  assign push_rec.has_sum    = is_end;
  assign push_rec.total      = sum_after;

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      in_number    <= 1'b0;
      is_negative  <= 1'b0;
      saw_digit    <= 1'b0;
      magnitude    <= 32'd0;
      skip_current <= 1'b0;
      row_count    <= 16'd0;
      row_skip     <= 1'b0;
      line_number  <= 32'd1;
      running_sum  <= 32'd0;
    end else if (accept) begin
      in_number    <= in_number_next;
      is_negative  <= is_negative_next;
      saw_digit    <= saw_digit_next;
      magnitude    <= magnitude_next;
      skip_current <= skip_current_next;
      row_count    <= row_count_next;
      row_skip     <= row_skip_next;
      line_number  <= line_number_next;
      running_sum  <= running_sum_next;
    end
  end

endmodule

### src/trlis_queue.sv
// ----------------------------------------------------------------------------
// trlis_queue
// short record queue between parser and output stage
// ----------------------------------------------------------------------------
module trlis_queue #(
  parameter int DEPTH = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  trlis_pkg::rec_t       push_rec,
  input  logic                  pop,
  output trlis_pkg::rec_t       head_rec,
  output trlis_pkg::q_status_t  status
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  trlis_pkg::rec_t slots [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic            do_push;
  logic            do_pop;

  assign status.full  = (count == FULL_COUNT);
  assign status.empty = (count == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head_rec     = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_rec;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

### src/trlis_back.sv
// ----------------------------------------------------------------------------
// trlis_back
// output stage: splits queued records into result transactions
// ----------------------------------------------------------------------------
module trlis_back (
  input  logic                  clk,
  input  logic                  rst,
  input  trlis_pkg::rec_t       head_rec,
  input  trlis_pkg::q_status_t  q_status,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_kind,
  output logic [31:0]           out_value,
  output logic [31:0]           out_row,
  output logic [31:0]           out_total,
  output logic                  out_last
);

  logic        pend_sum;
  logic [31:0] pend_total;
  logic        load;

  assign load = !out_valid || out_ready;
  assign pop  = load && !pend_sum && !q_status.empty;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pend_sum  <= 1'b0;
    end else if (load) begin
      if (pend_sum) begin
        out_valid <= 1'b1;
        pend_sum  <= 1'b0;
      end else if (!q_status.empty) begin
        out_valid <= 1'b1;
        pend_sum  <= head_rec.has_warn && head_rec.has_sum;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      if (pend_sum) begin
        out_kind  <= trlis_pkg::KIND_SUM;
        out_value <= 32'd0;
        out_row   <= 32'd0;
        out_total <= pend_total;
        out_last  <= 1'b1;
      end else if (!q_status.empty) begin
        pend_total <= head_rec.total;
        if (head_rec.has_warn) begin
          out_kind  <= trlis_pkg::KIND_WARN;
          out_value <= head_rec.warn_value;
          out_row   <= head_rec.warn_row;
          out_total <= 32'd0;
          out_last  <= !head_rec.has_sum;
        end else begin
          out_kind  <= trlis_pkg::KIND_SUM;
          out_value <= 32'd0;
          out_row   <= 32'd0;
          out_total <= head_rec.total;
          out_last  <= 1'b1;
        end
      end
    end
  end

endmodule

### src/text_row_limited_integer_sum.sv
// ----------------------------------------------------------------------------
// text_row_limited_integer_sum
// signed integer finder and summer over a byte stream, with a per-line limit
// ----------------------------------------------------------------------------
// One text byte is taken per clock cycle, back to back: the parser updates its
// number, row and sum state as it takes the byte and hands any result record to a
// short queue, from which the output stage drives result transactions. An item
// that yields a warning and the final sum (end with a pending negative number)
// is sent as two result transactions, warning first. Input stalls only while the queue is
// full, i.e. when the result side is back-pressured. Registers are written over
// the APB port; per_row_limit lies at address 0 and resets to 65535.
module text_row_limited_integer_sum #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  // apb configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
  input  logic        s_axis_tuser,   // [0] is_end
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [95:0] m_axis_tdata,   // [31:0] warn_value, [63:32] warn_row, [95:64] total
  output logic        m_axis_tuser,   // [0] kind
  output logic        m_axis_tlast
);

  logic [15:0]          per_row_limit;
  logic                 push;
  logic                 pop;
  trlis_pkg::rec_t      push_rec;
  trlis_pkg::rec_t      head_rec;
  trlis_pkg::q_status_t q_status;
  logic [31:0]          out_value;
  logic [31:0]          out_row;
  logic [31:0]          out_total;

  // configuration register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == trlis_pkg::REG_PER_ROW_LIMIT) ? {16'd0, per_row_limit} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      per_row_limit <= trlis_pkg::LIMIT_RESET;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[2] == trlis_pkg::REG_PER_ROW_LIMIT)) begin
      per_row_limit <= pwdata[15:0];
    end
  end

  // parser
  trlis_front u_front (
    .clk           (clk),
    .rst           (rst),
    .per_row_limit (per_row_limit),
    .in_valid      (s_axis_tvalid),
    .in_ready      (s_axis_tready),
    .text_byte     (s_axis_tdata),
    .is_end        (s_axis_tuser),
    .q_full        (q_status.full),
    .push          (push),
    .push_rec      (push_rec)
  );

  // record queue
  trlis_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .head_rec (head_rec),
    .status   (q_status)
  );

  // output stage
  trlis_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head_rec  (head_rec),
    .q_status  (q_status),
    .pop       (pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_kind  (m_axis_tuser),
    .out_value (out_value),
    .out_row   (out_row),
    .out_total (out_total),
    .out_last  (m_axis_tlast)
  );

  assign m_axis_tdata = {out_total, out_row, out_value};

  // checks
`include "text_row_limited_integer_sum_assert.svh"

  `TRLIS_ASSERT_SAME(a_sum_is_last, clk, rst,
    m_axis_tvalid && (m_axis_tuser == trlis_pkg::KIND_SUM), m_axis_tlast)
  `TRLIS_ASSERT_SAME(a_warn_negative, clk, rst,
    m_axis_tvalid && (m_axis_tuser == trlis_pkg::KIND_WARN), m_axis_tdata[31])
  `TRLIS_ASSERT_NEXT(a_sum_follows_warn, clk, rst,
    m_axis_tvalid && m_axis_tready && !m_axis_tlast,
    m_axis_tvalid && (m_axis_tuser == trlis_pkg::KIND_SUM))

endmodule
